### rtl/hsv_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines
// assertion macros shared by the converter rtl, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication a fixed number of cycles later
`define HSV_ASSERT_LATER(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

### rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types and constants of the hsv to rgb converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

	// width of the hue sector index
	localparam int SECTOR_W = 3;

	// hue sector, named by its (red, green, blue) ordering
	typedef enum logic [SECTOR_W-1:0] {
		SECT_VTP = 3'd0,
		SECT_QVP = 3'd1,
		SECT_PVT = 3'd2,
		SECT_PQV = 3'd3,
		SECT_TPV = 3'd4,
		SECT_VPQ = 3'd5
	} sector_t;

	// pipeline latency from accepted beat to result strobe
	localparam int LATENCY = 4;

endpackage

`default_nettype wire

### rtl/hsv_fxmul.sv
// ----------------------------------------------------------------------------
// hsv_fxmul
// registered fixed-point multiply, product truncated by the fraction width
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_fxmul #(
	parameter int A_W   = 17,
	parameter int B_W   = 17,
	parameter int FRAC  = 16,
	parameter int OUT_W = 17
) (
	input  wire logic             clk,
	input  wire logic [A_W-1:0]   a,
	input  wire logic [B_W-1:0]   b,
	output logic      [OUT_W-1:0] y
);

	logic [A_W+B_W-1:0] prod;
	logic [A_W+B_W-1:0] prod_shr;
	logic [OUT_W-1:0]   y_q;

	// full product, then drop the fraction bits
	assign prod     = a * b;
	assign prod_shr = prod >> FRAC;

	always_ff @(posedge clk) begin
		y_q <= prod_shr[OUT_W-1:0];
	end

	assign y = y_q;

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// hsv plus alpha to rgb plus alpha, fixed point, four stage pipeline
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------
//  pixel in | in  | start / busy    | hue, saturation, brightness, opacity
//  pixel out| out | done (strobe)   | red, green, blue, alpha_out
//
//  a beat is taken at every edge with start high and busy low; busy stays low,
//  so one pixel enters per clock.
//  each result shows on done one cycle wide, after its beat has passed the
//  four register stages (clamp and sector, first multiplies, second
//  multiplies, sector select) in that order.
//  arst_n clears the valid bits only; in-flight pixels are dropped.
//  the receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [FRAC_BITS-1:0] hue,
	input  wire logic [FRAC_BITS:0]   saturation,
	input  wire logic [FRAC_BITS:0]   brightness,
	input  wire logic [FRAC_BITS:0]   opacity,
	output logic                      done,
	output logic      [FRAC_BITS:0]   red,
	output logic      [FRAC_BITS:0]   green,
	output logic      [FRAC_BITS:0]   blue,
	output logic      [FRAC_BITS:0]   alpha_out
);

	import hsv_pkg::*;

	localparam int FX_W = FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic                       accept;
	logic [FRAC_BITS:0]         sat_clamp;
	logic [FRAC_BITS:0]         val_clamp;
	logic [FRAC_BITS+2:0]       h6;

	// stage 1
	logic                       vld_s1;
	logic [FRAC_BITS:0]         sat_s1;
	logic [FRAC_BITS:0]         sinv_s1;
	logic [FRAC_BITS:0]         val_s1;
	logic [FRAC_BITS:0]         alpha_s1;
	logic [FRAC_BITS-1:0]       f_s1;
	logic [FRAC_BITS:0]         finv_s1;
	sector_t                    sector_s1;
	logic                       grey_s1;

	// stage 2
	logic                       vld_s2;
	logic [FRAC_BITS:0]         sf_s2;
	logic [FRAC_BITS:0]         sfi_s2;
	logic [FRAC_BITS:0]         p_s2;
	logic [FRAC_BITS:0]         val_s2;
	logic [FRAC_BITS:0]         alpha_s2;
	sector_t                    sector_s2;
	logic                       grey_s2;
	logic [FRAC_BITS:0]         qfac;
	logic [FRAC_BITS:0]         tfac;

	// stage 3
	logic                       vld_s3;
	logic [FRAC_BITS:0]         q_s3;
	logic [FRAC_BITS:0]         t_s3;
	logic [FRAC_BITS:0]         p_s3;
	logic [FRAC_BITS:0]         val_s3;
	logic [FRAC_BITS:0]         alpha_s3;
	sector_t                    sector_s3;
	logic                       grey_s3;

	// stage 4
	logic                       vld_s4;
	logic [FRAC_BITS:0]         red_s4;
	logic [FRAC_BITS:0]         green_s4;
	logic [FRAC_BITS:0]         blue_s4;
	logic [FRAC_BITS:0]         alpha_s4;
	logic [FRAC_BITS:0]         red_nxt;
	logic [FRAC_BITS:0]         green_nxt;
	logic [FRAC_BITS:0]         blue_nxt;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// clamp to one and split hue*6 into sector and fraction
	assign sat_clamp = (saturation > ONE) ? ONE : saturation;
	assign val_clamp = (brightness > ONE) ? ONE : brightness;
	assign h6        = ({2'b00, hue, 1'b0}) + ({1'b0, hue, 2'b00});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		sat_s1    <= sat_clamp;
		sinv_s1   <= ONE - sat_clamp;
		val_s1    <= val_clamp;
		alpha_s1  <= opacity;
		f_s1      <= h6[FRAC_BITS-1:0];
		finv_s1   <= ONE - {1'b0, h6[FRAC_BITS-1:0]};
		sector_s1 <= sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
		grey_s1   <= (saturation == '0);
	end

	// stage 2 products: s*f, s*(1-f), v*(1-s)
	hsv_fxmul #(.A_W(FX_W), .B_W(FRAC_BITS), .FRAC(FRAC_BITS), .OUT_W(FX_W)) u_mul_sf (
		.clk (clk),
		.a   (sat_s1),
		.b   (f_s1),
		.y   (sf_s2)
	);

	hsv_fxmul #(.A_W(FX_W), .B_W(FX_W), .FRAC(FRAC_BITS), .OUT_W(FX_W)) u_mul_sfi (
		.clk (clk),
		.a   (sat_s1),
		.b   (finv_s1),
		.y   (sfi_s2)
	);

	hsv_fxmul #(.A_W(FX_W), .B_W(FX_W), .FRAC(FRAC_BITS), .OUT_W(FX_W)) u_mul_p (
		.clk (clk),
		.a   (val_s1),
		.b   (sinv_s1),
		.y   (p_s2)
	);

	always_ff @(posedge clk) begin
		val_s2    <= val_s1;
		alpha_s2  <= alpha_s1;
		sector_s2 <= sector_s1;
		grey_s2   <= grey_s1;
	end

	// stage 3 products: q = v*(1-s*f), t = v*(1-s*(1-f))
	assign qfac = ONE - sf_s2;
	assign tfac = ONE - sfi_s2;

	hsv_fxmul #(.A_W(FX_W), .B_W(FX_W), .FRAC(FRAC_BITS), .OUT_W(FX_W)) u_mul_q (
		.clk (clk),
		.a   (val_s2),
		.b   (qfac),
		.y   (q_s3)
	);

	hsv_fxmul #(.A_W(FX_W), .B_W(FX_W), .FRAC(FRAC_BITS), .OUT_W(FX_W)) u_mul_t (
		.clk (clk),
		.a   (val_s2),
		.b   (tfac),
		.y   (t_s3)
	);

	always_ff @(posedge clk) begin
		p_s3      <= p_s2;
		val_s3    <= val_s2;
		alpha_s3  <= alpha_s2;
		sector_s3 <= sector_s2;
		grey_s3   <= grey_s2;
	end

	// sector ordering, grey when saturation is zero
	always_comb begin
		red_nxt   = val_s3;
		green_nxt = val_s3;
		blue_nxt  = val_s3;
		if (!grey_s3) begin
			case (sector_s3)
				SECT_VTP: begin
					red_nxt   = val_s3;
					green_nxt = t_s3;
					blue_nxt  = p_s3;
				end
				SECT_QVP: begin
					red_nxt   = q_s3;
					green_nxt = val_s3;
					blue_nxt  = p_s3;
				end
				SECT_PVT: begin
					red_nxt   = p_s3;
					green_nxt = val_s3;
					blue_nxt  = t_s3;
				end
				SECT_PQV: begin
					red_nxt   = p_s3;
					green_nxt = q_s3;
					blue_nxt  = val_s3;
				end
				SECT_TPV: begin
					red_nxt   = t_s3;
					green_nxt = p_s3;
					blue_nxt  = val_s3;
				end
				default: begin
					red_nxt   = val_s3;
					green_nxt = p_s3;
					blue_nxt  = q_s3;
				end
			endcase
		end
	end

	// stage 4 output registers
	always_ff @(posedge clk) begin
		red_s4   <= red_nxt;
		green_s4 <= green_nxt;
		blue_s4  <= blue_nxt;
		alpha_s4 <= alpha_s3;
	end

	assign done      = vld_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;
	assign alpha_out = alpha_s4;

	// every accepted beat comes out after the fixed latency
	`HSV_ASSERT_LATER(a_beat_out, accept, LATENCY, done, "accepted beat produced no result")

	// a zero-saturation pixel comes out grey
	`HSV_ASSERT_LATER(a_grey, accept && (saturation == '0), LATENCY, (red == green) && (green == blue), "grey pixel has unequal channels")

	// colour channels never exceed one
	`HSV_ASSERT_NOW(a_range, done, (red <= ONE) && (green <= ONE) && (blue <= ONE), "colour channel above one")

	// alpha travels unchanged
	`HSV_ASSERT_NOW(a_alpha, done, alpha_out == $past(opacity, LATENCY), "alpha changed in flight")

endmodule

`default_nettype wire

### bench/hsv_to_rgb_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// watches the pixel beats going into the converter, predicts the rgba result
// of each one and compares it with the result strobed out on done, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [FRAC_BITS-1:0] hue,
	input  logic [FRAC_BITS:0]   saturation,
	input  logic [FRAC_BITS:0]   brightness,
	input  logic [FRAC_BITS:0]   opacity,
	input  logic                 done,
	input  logic [FRAC_BITS:0]   red,
	input  logic [FRAC_BITS:0]   green,
	input  logic [FRAC_BITS:0]   blue,
	input  logic [FRAC_BITS:0]   alpha_out,
	output int                   errors,
	output int                   outstanding
);

	import hsv_pkg::*;

	// far more slots than beats can be in flight
	localparam int EXP_DEPTH = 64;

	typedef struct packed {
		logic [FRAC_BITS:0] red;
		logic [FRAC_BITS:0] green;
		logic [FRAC_BITS:0] blue;
		logic [FRAC_BITS:0] alpha;
	} rgba_t;

	// predictions in a ring, oldest at the read count
	rgba_t       expected_ring [EXP_DEPTH];
	int unsigned expected_wr    = 0;
	int unsigned expected_rd    = 0;
	int          mismatch_count = 0;

	// values above 1.0 are pinned to 1.0
	function automatic longint unsigned clamp_unit(input logic [FRAC_BITS:0] x);
		longint unsigned one;
		one = 64'd1 << FRAC_BITS;
		return (x > one) ? one : longint'(x);
	endfunction

	// fixed-point hsv to rgb, products truncated to FRAC_BITS fraction bits
	function automatic rgba_t hsv_to_rgba(
		input logic [FRAC_BITS-1:0] h,
		input logic [FRAC_BITS:0]   s_in,
		input logic [FRAC_BITS:0]   v_in,
		input logic [FRAC_BITS:0]   a_in
	);
		longint unsigned  one, s, v, h6, f, p, q, t;
		logic [SECTOR_W-1:0] sector_bits;
		sector_t          sector;
		rgba_t            res;
		one = 64'd1 << FRAC_BITS;
		s = clamp_unit(s_in);
		v = clamp_unit(v_in);
		res.alpha = a_in;
		if (s == 0) begin
			res.red   = v[FRAC_BITS:0];
			res.green = v[FRAC_BITS:0];
			res.blue  = v[FRAC_BITS:0];
		end else begin
			h6 = h;
			h6 = h6 * 6;
			sector_bits = h6[FRAC_BITS +: SECTOR_W];
			sector = sector_t'(sector_bits);
			f = h6 & (one - 1);
			p = (v * (one - s)) >> FRAC_BITS;
			q = (v * (one - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
			t = (v * (one - ((s * (one - f)) >> FRAC_BITS))) >> FRAC_BITS;
			case (sector)
				SECT_VTP: begin
					res.red = v[FRAC_BITS:0]; res.green = t[FRAC_BITS:0]; res.blue = p[FRAC_BITS:0];
				end
				SECT_QVP: begin
					res.red = q[FRAC_BITS:0]; res.green = v[FRAC_BITS:0]; res.blue = p[FRAC_BITS:0];
				end
				SECT_PVT: begin
					res.red = p[FRAC_BITS:0]; res.green = v[FRAC_BITS:0]; res.blue = t[FRAC_BITS:0];
				end
				SECT_PQV: begin
					res.red = p[FRAC_BITS:0]; res.green = q[FRAC_BITS:0]; res.blue = v[FRAC_BITS:0];
				end
				SECT_TPV: begin
					res.red = t[FRAC_BITS:0]; res.green = p[FRAC_BITS:0]; res.blue = v[FRAC_BITS:0];
				end
				default: begin
					res.red = v[FRAC_BITS:0]; res.green = p[FRAC_BITS:0]; res.blue = q[FRAC_BITS:0];
				end
			endcase
		end
		return res;
	endfunction

	// compare each result beat with the oldest prediction, then queue new ones
	always @(posedge clk or negedge arst_n) begin
		rgba_t expected;
		if (!arst_n) begin
			expected_wr = 0;
			expected_rd = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_wr == expected_rd) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: r=%0d g=%0d b=%0d a=%0d",
							red, green, blue, alpha_out);
				end else begin
					expected = expected_ring[expected_rd % EXP_DEPTH];
					expected_rd++;
					if (red !== expected.red || green !== expected.green ||
							blue !== expected.blue || alpha_out !== expected.alpha) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
								expected.red, expected.green, expected.blue, expected.alpha,
								red, green, blue, alpha_out);
					end
				end
			end
			if (start && !busy) begin
				expected_ring[expected_wr % EXP_DEPTH] =
					hsv_to_rgba(hue, saturation, brightness, opacity);
				expected_wr++;
			end
			errors <= mismatch_count;
			outstanding <= int'(expected_wr - expected_rd);
		end
	end

endmodule

### bench/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// drives directed corner pixels (sector edges, grey, inputs above 1.0) and
// then random pixels with idle bursts into the converter; the checker beside
// the block predicts and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

	localparam int FRAC_BITS     = 16;
	localparam int FX_W          = FRAC_BITS + 1;
	localparam int RANDOM_PIXELS = 1250;
	localparam int BURST_FREE    = 200;
	localparam int CYCLE_LIMIT   = 100000;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic [FRAC_BITS-1:0] hue        = '0;
	logic [FRAC_BITS:0]   saturation = '0;
	logic [FRAC_BITS:0]   brightness = '0;
	logic [FRAC_BITS:0]   opacity    = '0;
	logic                 busy;
	logic                 done;
	logic [FRAC_BITS:0]   red, green, blue, alpha_out;
	int                   mismatch_total;
	int                   pending_results;
	int                   cycle_count = 0;

	always #10 clk = ~clk;

	hsv_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.hue(hue), .saturation(saturation), .brightness(brightness), .opacity(opacity),
		.done(done), .red(red), .green(green), .blue(blue), .alpha_out(alpha_out)
	);

	hsv_to_rgb_converter_checker #(
		.FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.hue(hue), .saturation(saturation), .brightness(brightness), .opacity(opacity),
		.done(done), .red(red), .green(green), .blue(blue), .alpha_out(alpha_out),
		.errors(mismatch_total), .outstanding(pending_results)
	);

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter_tb NOT OK");
			$finish;
		end
	end

	// present one pixel and hold it until the beat is taken
	task automatic send_pixel(
		input logic [FRAC_BITS-1:0] h,
		input logic [FRAC_BITS:0]   s,
		input logic [FRAC_BITS:0]   v,
		input logic [FRAC_BITS:0]   a
	);
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		opacity <= a;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// q1.16 value: mostly in range, some corners, some above 1.0
	function automatic logic [FRAC_BITS:0] rand_unit();
		logic [FRAC_BITS:0] x;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: x = '0;
					1: x = FX_W'(1);
					2: x = FX_W'((1 << FRAC_BITS) - 1);
					3: x = FX_W'(1 << FRAC_BITS);
					4: x = FX_W'((1 << FRAC_BITS) + 1);
					default: x = '1;
				endcase
			end
			1, 2: x = FX_W'($urandom_range(0, (2 << FRAC_BITS) - 1));
			default: x = FX_W'($urandom_range(0, 1 << FRAC_BITS));
		endcase
		return x;
	endfunction

	// hue: mostly uniform, sometimes right around a sector edge
	function automatic logic [FRAC_BITS-1:0] rand_hue();
		int unsigned edge_pos;
		logic [FRAC_BITS-1:0] h;
		if ($urandom_range(0, 7) == 0) begin
			edge_pos = ($urandom_range(0, 5) * (1 << FRAC_BITS) + 5) / 6;
			h = FRAC_BITS'(edge_pos + $urandom_range(0, 6) - 3);
		end else begin
			h = FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
		end
		return h;
	endfunction

	initial begin
		logic [FRAC_BITS:0] sat;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sector edges, at full saturation and value first, then at lower ones
		send_pixel(16'd0,     17'd65536, 17'd65536, 17'd65536);
		send_pixel(16'd10922, 17'd65536, 17'd65536, 17'd0);
		send_pixel(16'd10923, 17'd65536, 17'd65536, 17'd1);
		send_pixel(16'd21845, 17'd65536, 17'd65536, 17'd65535);
		send_pixel(16'd21846, 17'd32768, 17'd65536, 17'd65536);
		send_pixel(16'd32767, 17'd32768, 17'd40000, 17'd65536);
		send_pixel(16'd32768, 17'd32768, 17'd40000, 17'd65536);
		send_pixel(16'd43690, 17'd12345, 17'd65535, 17'd65536);
		send_pixel(16'd43691, 17'd12345, 17'd65535, 17'd65536);
		send_pixel(16'd54613, 17'd50000, 17'd65536, 17'd65536);
		send_pixel(16'd54614, 17'd50000, 17'd65536, 17'd65536);
		send_pixel(16'd65535, 17'd65536, 17'd65536, 17'd65536);
		// grey, including clamped value
		send_pixel(16'd30000, 17'd0,     17'd32768, 17'd65536);
		send_pixel(16'd65535, 17'd0,     17'd131071, 17'd0);
		send_pixel(16'd0,     17'd0,     17'd0,     17'd65536);
		// saturation and value above 1.0, tiny values
		send_pixel(16'd5000,  17'd65537, 17'd65536, 17'd65536);
		send_pixel(16'd40000, 17'd131071, 17'd50000, 17'd65536);
		send_pixel(16'd20000, 17'd65536, 17'd65537, 17'd65536);
		send_pixel(16'd60000, 17'd40000, 17'd131071, 17'd65536);
		send_pixel(16'd15000, 17'd1,     17'd65536, 17'd65536);
		send_pixel(16'd50000, 17'd65536, 17'd1,     17'd65536);
		send_pixel(16'd25000, 17'd65536, 17'd0,     17'd65536);
		// opacity above 1.0 passes through
		send_pixel(16'd12345, 17'd30000, 17'd30000, 17'd131071);
		send_pixel(16'd54321, 17'd30000, 17'd30000, 17'd65537);

		// random pixels, idle bursts except in the tail
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i < RANDOM_PIXELS - BURST_FREE && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			sat = ($urandom_range(0, 15) == 0) ? '0 : rand_unit();
			send_pixel(rand_hue(), sat, rand_unit(), rand_unit());
		end
		start <= 1'b0;

		// drain the pipeline, then watch for stray beats
		wait (pending_results == 0);
		repeat (hsv_pkg::LATENCY + 8) @(posedge clk);
		if (mismatch_total == 0 && pending_results == 0)
			$display("hsv_to_rgb_converter_tb OK");
		else
			$display("hsv_to_rgb_converter_tb NOT OK");
		$finish;
	end

endmodule
